// ===== hdl/hfd_pkg.sv =====
package hfd_pkg;

    localparam int FracBits = 56;
    localparam int SigBits  = 52;
    localparam int ExpBias  = 1023;
    localparam int HexBias  = 64;
    localparam int LeadW    = 6;
    localparam int ExpW     = 11;

    // Stage one to stage two: leading one found, exponent not yet formed.
    typedef struct packed {
        logic                sign;
        logic                zero;
        logic [6:0]          hexp;
        logic [LeadW-1:0]    lead;
        logic [FracBits-1:0] frac;
    } hfd_lead_t;

    // Stage two to stage three: normalised significand with round bits.
    typedef struct packed {
        logic                sign;
        logic                zero;
        logic [ExpW-1:0]     bexp;
        logic [SigBits+3:0]  sig;   // 53 bits of significand then 3 bits below
    } hfd_norm_t;

endpackage

// ===== hdl/hfd_lead.sv =====
module hfd_lead (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [63:0]                 hex_float,
    output logic                        out_valid,
    output hfd_pkg::hfd_lead_t          out_data
);

    logic               valid_reg;
    hfd_pkg::hfd_lead_t data_reg;
    hfd_pkg::hfd_lead_t data_next;
    logic [hfd_pkg::FracBits-1:0] frac;

    // Leading one search over the fraction, highest position wins.
    always_comb
    begin
        frac = hex_float[hfd_pkg::FracBits-1:0];
        data_next.sign = hex_float[63];
        data_next.hexp = hex_float[62:56];
        data_next.frac = frac;
        data_next.zero = (frac == '0);
        data_next.lead = '0;
        for (int i = 0; i < hfd_pkg::FracBits; i++)
        begin
            if (frac[i])
            begin
                data_next.lead = hfd_pkg::LeadW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/hfd_norm.sv =====
module hfd_norm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  hfd_pkg::hfd_lead_t          in_data,
    output logic                        out_valid,
    output hfd_pkg::hfd_norm_t          out_data
);

    logic               valid_reg;
    hfd_pkg::hfd_norm_t data_reg;
    hfd_pkg::hfd_norm_t data_next;
    logic [59:0]        wide;
    logic [12:0]        e;

    // Shift the leading one to bit 59 of a 60-bit word; 55 - lead never goes negative.
    always_comb
    begin
        wide = {in_data.frac, 4'b0000} << (6'd55 - in_data.lead);
        e = 13'({in_data.hexp, 2'b00}) + 13'(in_data.lead)
            + 13'(hfd_pkg::ExpBias - 4 * hfd_pkg::HexBias - hfd_pkg::FracBits);
        data_next.sign = in_data.sign;
        data_next.zero = in_data.zero;
        data_next.bexp = e[hfd_pkg::ExpW-1:0];
        data_next.sig  = wide[59:4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/hfd_round.sv =====
module hfd_round (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  hfd_pkg::hfd_norm_t          in_data,
    output logic                        out_valid,
    output logic [63:0]                 out_data
);

    logic        valid_reg;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [52:0] mant;
    logic [2:0]  rem;
    logic        up;
    logic [53:0] sum;
    logic [10:0] bexp;

    // Nearest, ties to even; the rest bits beyond the three kept are zero.
    always_comb
    begin
        mant = in_data.sig[55:3];
        rem  = in_data.sig[2:0];
        up   = rem[2] & ((rem[1:0] != 2'b00) | mant[0]);
        sum  = {1'b0, mant} + 54'(up);
        bexp = in_data.bexp + 11'(sum[53]);
        if (in_data.zero)
        begin
            data_next = {in_data.sign, 63'b0};
        end
        else if (sum[53])
        begin
            data_next = {in_data.sign, bexp, sum[52:1]};
        end
        else
        begin
            data_next = {in_data.sign, bexp, sum[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/hex_float_to_ieee_double_core.sv =====
// Results: a done strobe follows each accepted start through the lead, norm and round registers.
// Throughput: one transaction per cycle; busy is never raised.
// Stages: leading one search, normalising shift, rounding.
// Reset clears only the stage valid bits; the receiver cannot stall.
module hex_float_to_ieee_double_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] hex_float,
    output logic        done,
    output logic [63:0] ieee_double
);

    logic               lead_valid;
    hfd_pkg::hfd_lead_t lead_data;
    logic               norm_valid;
    hfd_pkg::hfd_norm_t norm_data;

    assign busy = 1'b0;

    hfd_lead u_lead (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .hex_float(hex_float),
        .out_valid(lead_valid), .out_data(lead_data)
    );

    hfd_norm u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(lead_valid), .in_data(lead_data),
        .out_valid(norm_valid), .out_data(norm_data)
    );

    hfd_round u_round (
        .clk(clk), .rst_n(rst_n), .in_valid(norm_valid), .in_data(norm_data),
        .out_valid(done), .out_data(ieee_double)
    );

endmodule

// ===== hdl/hfd_checker.sv =====
module hfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] hex_float,
    input logic        done,
    input logic [63:0] ieee_double
);

    // Every transaction yields a strobe.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done) else $error("missing result");

    // No strobe without an earlier transaction.
    a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3)) else $error("spurious result");

    // The sign passes through unchanged.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 (ieee_double[63] == $past(hex_float[63], 3)))
        else $error("sign mismatch");

    // A zero fraction gives a signed zero.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (hex_float[55:0] == 56'd0)
        |-> ##3 (ieee_double[62:0] == 63'd0)) else $error("zero wrong");

endmodule

bind hex_float_to_ieee_double_core hfd_checker u_hfd_checker (.*);
